// ----- rtl/core/sprs_pkg.sv -----
// Shared types and constants for the slotted page record store.
package sprs_pkg;

    // Field widths of the stream words and the configuration register
    localparam int REQ_W       = 2;
    localparam int SIZE_W      = 16;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int PAGE_IDX_W  = 5;
    localparam int SLOT_IDX_W  = 6;
    localparam int COUNT_W     = 7;
    localparam int PAGE_SIZE_W = 17;

    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = 17'd4096;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STATUS = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STS_TOO_LARGE = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_NEW,
        ST_SR_PG,
        ST_SR_CNT,
        ST_SR_KEY,
        ST_STAT_RD,
        ST_STAT_CHK,
        ST_EMIT
    } sprs_state_t;

endpackage

// ----- rtl/core/sprs_ram.sv -----
// Simple dual-port RAM with one write port and a registered read port.
module sprs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/slotted_page_record_store.sv -----
// Insert scans the open pages for room before opening a new one; search reads each open page's
// record count and then its stored keys; status sends the page count, then one word per open page.
// Throughput: one request at a time; the sequencer takes a new request only in its idle state.
// A result waits in the output register, so the next request is taken while it is held.
// Reset clears the sequencer, the page count and the output valid, and loads page_size 4096;
// the key and page RAMs are not cleared, only entries that were written are ever used.
module slotted_page_record_store
    import sprs_pkg::*;
#(
    parameter int MAX_PAGES     = 32,
    parameter int MAX_SLOTS     = 64,
    parameter int SLOT_OVERHEAD = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wen,
    input  logic [PAGE_SIZE_W-1:0] cfg_wdata,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [47:0]            s_tdata,   // [15:0] record_size, [47:16] key
    input  logic [1:0]             s_tuser,   // [1:0] req_type
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [4:0] page_index, [10:5] slot_index,
                                              // [17:11] count_value, [23:18] zero
    output logic [2:0]             m_tuser,   // [2:0] status
    output logic                   m_tlast    // last
);

    localparam int PIW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PW   = $clog2(MAX_PAGES + 1);
    localparam int SIW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCW  = $clog2(MAX_SLOTS + 1);
    localparam int KAW  = PIW + SIW;
    localparam int KDEPTH = MAX_PAGES * (2 ** SIW);
    localparam int PGW  = SCW + PAGE_SIZE_W;
    localparam int HDR_BYTES = 4 * SLOT_OVERHEAD;

    sprs_state_t state_reg, state_next;

    logic [PW-1:0]          pages_open_reg, pages_open_next;
    logic [PAGE_SIZE_W-1:0] page_size_reg;
    logic [PW-1:0]          p_reg, p_next;
    logic [SCW-1:0]         s_reg, s_next;
    logic [SCW-1:0]         n_reg, n_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [SIW-1:0]         cmp_slot_reg, cmp_slot_next;
    logic [PAGE_SIZE_W-1:0] need_reg, need_next;
    logic signed [KEY_W-1:0] key_reg, key_next;

    // pending result
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PAGE_IDX_W-1:0] res_page_reg, res_page_next;
    logic [SLOT_IDX_W-1:0] res_slot_reg, res_slot_next;
    logic [COUNT_W-1:0]    res_count_reg, res_count_next;
    logic                  res_last_reg, res_last_next;

    // output register
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [PAGE_IDX_W-1:0] m_page_reg;
    logic [SLOT_IDX_W-1:0] m_slot_reg;
    logic [COUNT_W-1:0]    m_count_reg;
    logic                  m_last_reg;
    logic                  out_free;
    logic                  out_load;

    // RAM ports
    logic                   pg_we;
    logic [PIW-1:0]         pg_waddr;
    logic [PGW-1:0]         pg_wdata;
    logic [PGW-1:0]         pg_rdata;
    logic                   key_we;
    logic [KAW-1:0]         key_waddr;
    logic [KAW-1:0]         key_raddr;
    logic [KEY_W-1:0]       key_rdata;

    logic [SCW-1:0]         pg_cnt;
    logic [PAGE_SIZE_W-1:0] pg_space;
    logic [PAGE_SIZE_W-1:0] fresh_space;
    logic                   pg_fits;
    logic                   key_hit;

    assign pg_cnt   = pg_rdata[PAGE_SIZE_W +: SCW];
    assign pg_space = pg_rdata[PAGE_SIZE_W-1:0];
    assign pg_fits  = (pg_cnt < SCW'(MAX_SLOTS)) && (need_reg <= pg_space);
    assign key_hit  = cmp_vld_reg && (key_rdata == $unsigned(key_reg));
    assign fresh_space = (page_size_reg >= PAGE_SIZE_W'(HDR_BYTES)) ?
                         page_size_reg - PAGE_SIZE_W'(HDR_BYTES) : '0;

    assign out_free = !m_valid_reg || m_tready;
    assign key_raddr = {p_reg[PIW-1:0], s_reg[SIW-1:0]};

    // Page table: {record count, bytes free} per page
    sprs_ram #(
        .WIDTH (PGW),
        .DEPTH (MAX_PAGES),
        .AW    (PIW)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (p_reg[PIW-1:0]),
        .rdata (pg_rdata)
    );

    // Key store: one row of slots per page
    sprs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KDEPTH),
        .AW    (KAW)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata ($unsigned(key_reg)),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Sequencer: next state, RAM writes and result staging.
    // Writes land before the next request's reads, since every request
    // passes through the result and idle states in between.
    always_comb begin
        state_next      = state_reg;
        pages_open_next = pages_open_reg;
        p_next          = p_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        cmp_vld_next    = 1'b0;
        cmp_slot_next   = cmp_slot_reg;
        need_next       = need_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        res_last_next   = res_last_reg;
        s_tready        = 1'b0;
        out_load        = 1'b0;
        pg_we           = 1'b0;
        pg_waddr        = p_reg[PIW-1:0];
        pg_wdata        = '0;
        key_we          = 1'b0;
        key_waddr       = {p_reg[PIW-1:0], pg_cnt[SIW-1:0]};

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                p_next   = '0;
                need_next = {1'b0, s_tdata[SIZE_W-1:0]} + PAGE_SIZE_W'(SLOT_OVERHEAD);
                key_next  = $signed(s_tdata[SIZE_W +: KEY_W]);
                res_slot_next  = '0;
                res_count_next = '0;
                res_page_next  = '0;
                res_last_next  = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        REQ_INSERT: state_next = ST_INS_RD;
                        REQ_SEARCH: state_next = ST_SR_PG;
                        REQ_STATUS: begin
                            res_status_next = STS_DONE;
                            res_count_next  = COUNT_W'(pages_open_reg);
                            res_last_next   = (pages_open_reg == '0);
                            state_next      = ST_EMIT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            // Walk open pages for the first one with room
            ST_INS_RD: begin
                if (p_reg < pages_open_reg) begin
                    state_next = ST_INS_CHK;
                end else begin
                    state_next = ST_INS_NEW;
                end
            end

            ST_INS_CHK: begin
                if (pg_fits) begin
                    pg_we    = 1'b1;
                    pg_wdata = {pg_cnt + SCW'(1), pg_space - need_reg};
                    key_we   = 1'b1;
                    res_status_next = STS_DONE;
                    res_page_next   = PAGE_IDX_W'(p_reg);
                    res_slot_next   = SLOT_IDX_W'(pg_cnt);
                    state_next      = ST_EMIT;
                end else begin
                    p_next     = p_reg + PW'(1);
                    state_next = ST_INS_RD;
                end
            end

            // Open a fresh page (reporting too large if the record does not fit it), or report a full file
            ST_INS_NEW: begin
                pg_waddr  = pages_open_reg[PIW-1:0];
                key_waddr = {pages_open_reg[PIW-1:0], SIW'(0)};
                state_next = ST_EMIT;
                if (pages_open_reg >= PW'(MAX_PAGES)) begin
                    res_status_next = STS_FULL;
                end else begin
                    pages_open_next = pages_open_reg + PW'(1);
                    pg_we           = 1'b1;
                    res_page_next   = PAGE_IDX_W'(pages_open_reg);
                    if (need_reg <= fresh_space) begin
                        pg_wdata        = {SCW'(1), fresh_space - need_reg};
                        key_we          = 1'b1;
                        res_status_next = STS_DONE;
                    end else begin
                        pg_wdata        = {SCW'(0), fresh_space};
                        res_status_next = STS_TOO_LARGE;
                    end
                end
            end

            // Search: fetch the page's record count, or report not found after the last open page
            ST_SR_PG: begin
                if (p_reg < pages_open_reg) begin
                    state_next = ST_SR_CNT;
                end else begin
                    res_status_next = STS_NOT_FOUND;
                    state_next      = ST_EMIT;
                end
            end

            ST_SR_CNT: begin
                n_next     = pg_cnt;
                s_next     = '0;
                state_next = ST_SR_KEY;
            end

            // Stream slot reads, compare each one once its registered read data returns
            ST_SR_KEY: begin
                if (key_hit) begin
                    res_status_next = STS_FOUND;
                    res_page_next   = PAGE_IDX_W'(p_reg);
                    res_slot_next   = SLOT_IDX_W'(cmp_slot_reg);
                    state_next      = ST_EMIT;
                end else if (s_reg < n_reg) begin
                    cmp_vld_next  = 1'b1;
                    cmp_slot_next = s_reg[SIW-1:0];
                    s_next        = s_reg + SCW'(1);
                end else begin
                    p_next     = p_reg + PW'(1);
                    state_next = ST_SR_PG;
                end
            end

            // Status: after the page-count word, one word per open page
            ST_STAT_RD: begin
                state_next = ST_STAT_CHK;
            end

            ST_STAT_CHK: begin
                res_status_next = STS_DONE;
                res_page_next   = PAGE_IDX_W'(p_reg);
                res_slot_next   = '0;
                res_count_next  = COUNT_W'(pg_cnt);
                res_last_next   = (p_reg + PW'(1) == pages_open_reg);
                p_next          = p_reg + PW'(1);
                state_next      = ST_EMIT;
            end

            // Hand the staged result to the output register
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (res_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_STAT_RD;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pages_open_reg <= '0;
            page_size_reg  <= PAGE_SIZE_RESET;
            cmp_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pages_open_reg <= pages_open_next;
            cmp_vld_reg    <= cmp_vld_next;
            if (cfg_wen) begin
                page_size_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p_reg          <= p_next;
        s_reg          <= s_next;
        n_reg          <= n_next;
        cmp_slot_reg   <= cmp_slot_next;
        need_reg       <= need_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        res_last_reg   <= res_last_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_page_reg   <= res_page_reg;
            m_slot_reg   <= res_slot_reg;
            m_count_reg  <= res_count_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_count_reg, m_slot_reg, m_page_reg};

    // Page count never passes the page limit
    a_pages_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_open_reg <= PW'(MAX_PAGES))
        else $error("page count above limit");

    // A key is written only together with its page entry
    a_key_with_page: assert property (@(posedge aclk) disable iff (!aresetn)
        key_we |-> pg_we)
        else $error("key write without page update");

    // Page table changes only while placing an insert
    a_pg_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pg_we |-> (state_reg == ST_INS_CHK || state_reg == ST_INS_NEW))
        else $error("page write outside insert");

    // A taken request of a known kind blocks the input until its last result is handed to the output register
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready &&
         (s_tuser == REQ_INSERT || s_tuser == REQ_SEARCH || s_tuser == REQ_STATUS))
        |=> !s_tready)
        else $error("second request taken while busy");

endmodule
